// ===== rtl/blr_pkg.sv =====
// Shared types and constants of the line rasterizer.
// Used by every module of the block; depends on nothing else.
package blr_pkg;

	localparam int COORD_W = 6;
	localparam int COLOR_W = 24;
	localparam int ADDR_W = 16;
	localparam int SIZE_W = 7;
	localparam int ERR_W = 8;
	localparam int PROD_W = COORD_W + SIZE_W;
	localparam int LIMIT_W = 11;

	localparam logic [LIMIT_W-1:0] MAX_WIDTH = 11'd64;
	localparam logic [LIMIT_W-1:0] MAX_HEIGHT = 11'd64;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [SIZE_W-1:0] ROW_STRIDE_RESET = 7'd64;
	localparam logic [SIZE_W-1:0] PANEL_HEIGHT_RESET = 7'd64;
	localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 16'd0;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		REG_ROW_STRIDE = 2'd0,
		REG_PANEL_HEIGHT = 2'd1,
		REG_FRAME_BASE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] line_color;
	} line_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [ADDR_W-1:0] word_address;
		logic [COLOR_W-1:0] pixel_color;
		logic write_enable;
		logic last;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] target_col;
		logic [COORD_W-1:0] target_row;
		logic [COORD_W-1:0] abs_dx;
		logic [COORD_W-1:0] abs_dy;
		logic step_left;
		logic step_up;
		logic signed [ERR_W-1:0] error_term;
		logic [COLOR_W-1:0] color;
	} walk_cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0] row_stride;
		logic [SIZE_W-1:0] panel_height;
		logic [ADDR_W-1:0] frame_base;
	} cfg_t;

endpackage

// ===== rtl/blr_cfg_regs.sv =====
// Configuration register file of the line rasterizer behind an APB-style port.
// Depends on blr_pkg for the register map and reset values.
module blr_cfg_regs import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic [SIZE_W-1:0] row_stride_q;
	logic [SIZE_W-1:0] panel_height_q;
	logic [ADDR_W-1:0] frame_base_q;
	logic wr_en;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_sel = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= ROW_STRIDE_RESET;
			panel_height_q <= PANEL_HEIGHT_RESET;
			frame_base_q <= FRAME_BASE_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ROW_STRIDE: row_stride_q <= pwdata[SIZE_W-1:0];
				REG_PANEL_HEIGHT: panel_height_q <= pwdata[SIZE_W-1:0];
				REG_FRAME_BASE: frame_base_q <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ROW_STRIDE: prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, row_stride_q};
			REG_PANEL_HEIGHT: prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, panel_height_q};
			REG_FRAME_BASE: prdata = {{(APB_DATA_W-ADDR_W){1'b0}}, frame_base_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.row_stride = row_stride_q;
	assign cfg.panel_height = panel_height_q;
	assign cfg.frame_base = frame_base_q;

endmodule

// ===== rtl/blr_front.sv =====
// Front end: accepts line commands and works out deltas, step directions and
// the initial error term. Depends on blr_pkg.
module blr_front import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input line_cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic queue_full,
	output logic push,
	output walk_cmd_t push_cmd
);

	logic valid_s1;
	walk_cmd_t cmd_s1;
	walk_cmd_t classified;
	logic left;
	logic up;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;

	always_comb begin
		left = cmd.end_x <= cmd.start_x;
		up = cmd.end_y <= cmd.start_y;
		dx = left ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
		dy = up ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
		classified.start_col = cmd.start_x;
		classified.start_row = cmd.start_y;
		classified.target_col = cmd.end_x;
		classified.target_row = cmd.end_y;
		classified.abs_dx = dx;
		classified.abs_dy = dy;
		classified.step_left = left;
		classified.step_up = up;
		classified.error_term = $signed({2'b00, dx}) - $signed({2'b00, dy});
		classified.color = cmd.line_color;
	end

	assign cmd_stall = valid_s1 && queue_full;
	assign push = valid_s1 && !queue_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= classified;
		end
	end

endmodule

// ===== rtl/blr_cmd_queue.sv =====
// Short command queue between the front end and the line walker.
// Depends on blr_pkg for the command type and depth.
module blr_cmd_queue import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input walk_cmd_t push_cmd,
	output logic full,
	input logic pop,
	output walk_cmd_t head,
	output logic head_valid
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	walk_cmd_t mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == DEPTH_CNT;
	assign head_valid = count_q != '0;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/blr_walker.sv =====
// Back end: walks one line at a time with the Bresenham error term and
// forms address and clip flag in a two-stage output pipeline. Depends on blr_pkg.
module blr_walker import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input walk_cmd_t head,
	input logic head_valid,
	output logic pop,
	output pixel_t pix,
	output logic pix_valid,
	input logic pix_stall
);

	logic busy_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic signed [ERR_W-1:0] err_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic left_q;
	logic up_q;
	logic [COORD_W-1:0] tcol_q;
	logic [COORD_W-1:0] trow_q;
	logic [COLOR_W-1:0] color_q;

	logic valid_s1;
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [COLOR_W-1:0] color_s1;
	logic last_s1;

	logic valid_s2;
	pixel_t pix_s2;

	logic advance;
	logic done;
	logic emit;
	logic signed [ERR_W:0] e2;
	logic signed [ERR_W:0] dx9;
	logic signed [ERR_W:0] dy9;
	logic step_x;
	logic step_y;
	logic signed [ERR_W:0] err_next;
	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] addr;
	logic in_panel;

	assign advance = !(valid_s2 && pix_stall);
	assign done = busy_q && (col_q == tcol_q) && (row_q == trow_q);
	assign emit = advance && busy_q;
	assign pop = advance && head_valid && (!busy_q || done);

	always_comb begin
		e2 = {err_q, 1'b0};
		dx9 = $signed({3'b000, dx_q});
		dy9 = $signed({3'b000, dy_q});
		step_x = e2 > -dy9;
		step_y = e2 < dx9;
		err_next = $signed({err_q[ERR_W-1], err_q});
		if (step_x) begin
			err_next = err_next - dy9;
		end
		if (step_y) begin
			err_next = err_next + dx9;
		end
	end

	assign prod = {{(PROD_W-COORD_W){1'b0}}, row_q} * {{(PROD_W-SIZE_W){1'b0}}, cfg.row_stride};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			valid_s1 <= busy_q;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_q <= head.start_col;
			row_q <= head.start_row;
			err_q <= head.error_term;
			dx_q <= head.abs_dx;
			dy_q <= head.abs_dy;
			left_q <= head.step_left;
			up_q <= head.step_up;
			tcol_q <= head.target_col;
			trow_q <= head.target_row;
			color_q <= head.color;
		end else if (emit && !done) begin
			err_q <= err_next[ERR_W-1:0];
			if (step_x) begin
				col_q <= left_q ? col_q - 1'b1 : col_q + 1'b1;
			end
			if (step_y) begin
				row_q <= up_q ? row_q - 1'b1 : row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			prod_s1 <= prod;
			color_s1 <= color_q;
			last_s1 <= done;
		end
	end

	always_comb begin
		addr = cfg.frame_base + {{(ADDR_W-PROD_W){1'b0}}, prod_s1}
			+ {{(ADDR_W-COORD_W){1'b0}}, col_s1};
		in_panel = ({1'b0, col_s1} < cfg.row_stride)
			&& ({{(LIMIT_W-COORD_W){1'b0}}, col_s1} < MAX_WIDTH)
			&& ({1'b0, row_s1} < cfg.panel_height)
			&& ({{(LIMIT_W-COORD_W){1'b0}}, row_s1} < MAX_HEIGHT);
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pix_s2.pixel_x <= col_s1;
			pix_s2.pixel_y <= row_s1;
			pix_s2.word_address <= addr;
			pix_s2.pixel_color <= color_s1;
			pix_s2.write_enable <= in_panel;
			pix_s2.last <= last_s1;
		end
	end

	assign pix = pix_s2;
	assign pix_valid = valid_s2;

endmodule

// ===== rtl/bresenham_line_rasterizer_top.sv =====
// Top level of the Bresenham line rasterizer.
// Depends on blr_pkg, blr_cfg_regs, blr_front, blr_cmd_queue and blr_walker.
//
// A line command (two endpoints and a color) enters on the cmd channel and
// is accepted when cmd_valid is high and cmd_stall is low. The block emits
// one pixel transaction per point of the line on the pix channel, from the
// start point to the end point; the end point carries last.
// Each pixel carries its framebuffer word address and a write enable that is
// low when the point lies outside the configured panel.
// A taken command is registered in the front end, the queue and the walker
// state, then in the s1 and s2 output stages before its first pixel appears.
// A line has at most 64 points and streams at one pixel per cycle while
// pix_stall is low, the walker's rate; a queued next line follows without a gap.
// A two-entry queue holds classified commands, so cmd keeps being accepted
// while a line is drawn until the queue fills.
// When pix_stall is high the walker and its output pipeline hold; the front
// end stalls cmd once the queue is full.
// Reset clears all pending work and loads the registers with row_stride 64,
// panel_height 64 and frame_base 0. Registers are written over the APB port; the user
// must write them only while the block is idle, which the block itself does not enforce.
module bresenham_line_rasterizer_top import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	input line_cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_stall,
	output pixel_t pix,
	output logic pix_valid,
	input logic pix_stall
);

	cfg_t cfg;
	logic queue_full;
	logic push;
	walk_cmd_t push_cmd;
	logic pop;
	walk_cmd_t head;
	logic head_valid;

	blr_cfg_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	blr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	blr_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.head(head),
		.head_valid(head_valid)
	);

	blr_walker u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.pix(pix),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall)
	);

endmodule

// ===== rtl/blr_checker.sv =====
// Port-level checks of the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_top.
module blr_checker import blr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pixel_t pix,
	input logic pix_valid,
	input logic pix_stall
);

	logic pix_take;

	assign pix_take = pix_valid && !pix_stall;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("pixel transaction changed while stalled");

	a_line_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take && !pix.last |=> pix_valid)
		else $error("line interrupted before its last pixel");

	a_step_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take && !pix.last |=>
			((pix.pixel_x == $past(pix.pixel_x))
				|| (pix.pixel_x == $past(pix.pixel_x) + 6'd1)
				|| (pix.pixel_x == $past(pix.pixel_x) - 6'd1))
			&& ((pix.pixel_y == $past(pix.pixel_y))
				|| (pix.pixel_y == $past(pix.pixel_y) + 6'd1)
				|| (pix.pixel_y == $past(pix.pixel_y) - 6'd1))
			&& !((pix.pixel_x == $past(pix.pixel_x))
				&& (pix.pixel_y == $past(pix.pixel_y))))
		else $error("consecutive pixels of a line are not neighbors");

	a_color_kept: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take && !pix.last |=> pix.pixel_color == $past(pix.pixel_color))
		else $error("color changed within a line");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the Bresenham line rasterizer: a directed table of lines, then random
// lines under several panel settings, checked against typed pixels or a behavioral line walker.
// Depends on blr_pkg and bresenham_line_rasterizer_top.
module tb_top import blr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX = 10;
	localparam int NUM_PHASES = 8;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_t;

	typedef struct {
		line_cmd_t line;
		bit typed;
		pixel_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	line_cmd_t cmd;
	logic cmd_valid;
	logic cmd_stall;
	pixel_t pix;
	logic pix_valid;
	logic pix_stall = 1'b0;

	logic [SIZE_W-1:0] cfg_stride = ROW_STRIDE_RESET;
	logic [SIZE_W-1:0] cfg_height = PANEL_HEIGHT_RESET;
	logic [ADDR_W-1:0] cfg_base = FRAME_BASE_RESET;

	pixel_t pixel_q[$];
	int err_cnt = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;

	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int stall_period = 3;
	int stall_phase = 0;
	int run_left = 0;

	dir_row_t dir_rows [19] = '{
		'{'{6'd0, 6'd0, 6'd0, 6'd0, 24'h000000}, 1'b1,
			'{6'd0, 6'd0, 16'd0, 24'h000000, 1'b1, 1'b1}},
		'{'{6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF}, 1'b1,
			'{6'd63, 6'd63, 16'd4095, 24'hFFFFFF, 1'b1, 1'b1}},
		'{'{6'd63, 6'd0, 6'd63, 6'd0, 24'hAAAAAA}, 1'b1,
			'{6'd63, 6'd0, 16'd63, 24'hAAAAAA, 1'b1, 1'b1}},
		'{'{6'd0, 6'd63, 6'd0, 6'd63, 24'h555555}, 1'b1,
			'{6'd0, 6'd63, 16'd4032, 24'h555555, 1'b1, 1'b1}},
		'{'{6'd0, 6'd0, 6'd63, 6'd0, 24'hFFFFFF}, 1'b0, '0},
		'{'{6'd63, 6'd5, 6'd0, 6'd5, 24'h0F0F0F}, 1'b0, '0},
		'{'{6'd7, 6'd0, 6'd7, 6'd63, 24'hF0F0F0}, 1'b0, '0},
		'{'{6'd9, 6'd63, 6'd9, 6'd0, 24'h123456}, 1'b0, '0},
		'{'{6'd0, 6'd0, 6'd63, 6'd63, 24'hABCDEF}, 1'b0, '0},
		'{'{6'd63, 6'd63, 6'd0, 6'd0, 24'h000001}, 1'b0, '0},
		'{'{6'd0, 6'd63, 6'd63, 6'd0, 24'h800000}, 1'b0, '0},
		'{'{6'd63, 6'd0, 6'd0, 6'd63, 24'h7FFFFF}, 1'b0, '0},
		'{'{6'd10, 6'd0, 6'd12, 6'd63, 24'h00FF00}, 1'b0, '0},
		'{'{6'd0, 6'd5, 6'd63, 6'd7, 24'hFF00FF}, 1'b0, '0},
		'{'{6'd5, 6'd5, 6'd6, 6'd6, 24'h3C3C3C}, 1'b0, '0},
		'{'{6'd5, 6'd5, 6'd4, 6'd5, 24'hC3C3C3}, 1'b0, '0},
		'{'{6'd20, 6'd30, 6'd21, 6'd28, 24'h5A5A5A}, 1'b0, '0},
		'{'{6'd33, 6'd33, 6'd33, 6'd34, 24'hA5A5A5}, 1'b0, '0},
		'{'{6'd42, 6'd21, 6'd21, 6'd42, 24'hAAAAAA}, 1'b0, '0}
	};

	bresenham_line_rasterizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.pix(pix),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic log_error(string msg);
		if (err_cnt < REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic void predict_line(line_cmd_t line);
		int col, row, tcol, trow, dx, dy, err, e2, lim_w, lim_h;
		bit left, up, done;
		pixel_t p;
		col = line.start_x;
		row = line.start_y;
		tcol = line.end_x;
		trow = line.end_y;
		left = tcol <= col;
		up = trow <= row;
		dx = left ? col - tcol : tcol - col;
		dy = up ? row - trow : trow - row;
		err = dx - dy;
		lim_w = (cfg_stride > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(cfg_stride);
		lim_h = (cfg_height > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(cfg_height);
		for (int n = 0; n < 64; n++) begin
			done = (col == tcol) && (row == trow);
			p.pixel_x = col[COORD_W-1:0];
			p.pixel_y = row[COORD_W-1:0];
			p.word_address = ADDR_W'(int'(cfg_base) + row * int'(cfg_stride) + col);
			p.pixel_color = line.line_color;
			p.write_enable = (col < lim_w) && (row < lim_h);
			p.last = done;
			pixel_q.push_back(p);
			if (done)
				break;
			e2 = 2 * err;
			if (e2 > -dy) begin
				err -= dy;
				col = left ? (col - 1) & 63 : (col + 1) & 63;
			end
			if (e2 < dx) begin
				err += dx;
				row = up ? (row - 1) & 63 : (row + 1) & 63;
			end
		end
	endfunction

	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixel_q.size() == 0) begin
				log_error($sformatf("unexpected pixel x=%0d y=%0d addr=%h", pix.pixel_x,
					pix.pixel_y, pix.word_address));
			end else begin
				want = pixel_q.pop_front();
				if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y ||
					pix.word_address !== want.word_address ||
					pix.pixel_color !== want.pixel_color ||
					pix.write_enable !== want.write_enable || pix.last !== want.last)
					log_error($sformatf({"pixel mismatch exp x=%0d y=%0d a=%h c=%h we=%b l=%b",
						" got x=%0d y=%0d a=%h c=%h we=%b l=%b"},
						want.pixel_x, want.pixel_y, want.word_address, want.pixel_color,
						want.write_enable, want.last, pix.pixel_x, pix.pixel_y,
						pix.word_address, pix.pixel_color, pix.write_enable, pix.last));
			end
		end
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(30, 300);
			stall_period <= $urandom_range(2, 6);
		end else begin
			mode_left <= mode_left - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			STALL_NONE: begin
				pix_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				pix_stall <= ($urandom_range(0, 99) < 35);
			end
			STALL_PERIODIC: begin
				pix_stall <= ((stall_phase % stall_period) == 0);
			end
			default: begin
				if (run_left != 0) begin
					pix_stall <= 1'b1;
					run_left <= run_left - 1;
				end else if ($urandom_range(0, 15) == 0) begin
					pix_stall <= 1'b1;
					run_left <= $urandom_range(1, 7);
				end else begin
					pix_stall <= 1'b0;
				end
			end
		endcase
	end

	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value,
		logic [APB_DATA_W-1:0] mask);
		logic [APB_DATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if ((rd & mask) !== (value & mask))
			log_error($sformatf("register %s read %h, expected %h", idx.name(), rd & mask,
				value & mask));
	endtask

	task automatic set_panel(logic [SIZE_W-1:0] stride, logic [SIZE_W-1:0] height,
		logic [ADDR_W-1:0] base);
		apb_write(REG_ROW_STRIDE, APB_DATA_W'(stride), (1 << SIZE_W) - 1);
		apb_write(REG_PANEL_HEIGHT, APB_DATA_W'(height), (1 << SIZE_W) - 1);
		apb_write(REG_FRAME_BASE, APB_DATA_W'(base), (1 << ADDR_W) - 1);
		cfg_stride = stride;
		cfg_height = height;
		cfg_base = base;
	endtask

	task automatic send_line(line_cmd_t line, bit typed, pixel_t want);
		if (gaps_on && burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		cmd <= line;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		if (typed)
			pixel_q.push_back(want);
		else
			predict_line(line);
		if (burst_left > 0)
			burst_left--;
	endtask

	function automatic line_cmd_t random_line();
		line_cmd_t line;
		int kind;
		kind = $urandom_range(0, 9);
		line.start_x = COORD_W'($urandom_range(0, 63));
		line.start_y = COORD_W'($urandom_range(0, 63));
		line.end_x = COORD_W'($urandom_range(0, 63));
		line.end_y = COORD_W'($urandom_range(0, 63));
		line.line_color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
		case (kind)
			0: begin
				line.end_x = line.start_x;
				line.end_y = line.start_y;
			end
			1: line.end_y = line.start_y;
			2: line.end_x = line.start_x;
			3: begin
				line.end_x = line.start_x + COORD_W'($urandom_range(0, 6) - 3);
				line.end_y = line.start_y + COORD_W'($urandom_range(0, 6) - 3);
			end
			4: line.end_y = (line.end_x >= line.start_x) ?
				line.start_y + (line.end_x - line.start_x) :
				line.start_y - (line.start_x - line.end_x);
			default: ;
		endcase
		return line;
	endfunction

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_line(random_line(), 1'b0, '0);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [SIZE_W-1:0] strides [6] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd37, 7'd100};
		logic [SIZE_W-1:0] heights [6] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd50, 7'd9};
		logic [ADDR_W-1:0] bases [6] = '{16'h1234, 16'hFFFF, 16'hFFC0, 16'h0000, 16'h8001,
			16'hF000};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd = '0;
		cmd_valid = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_line(dir_rows[i].line, dir_rows[i].typed, dir_rows[i].want);
		send_random(60);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 6)
				set_panel(strides[ph], heights[ph], bases[ph]);
			else
				set_panel(SIZE_W'($urandom_range(0, 127)), SIZE_W'($urandom_range(0, 127)),
					ADDR_W'($urandom_range(0, 16'hFFFF)));
			gaps_on = ($urandom_range(0, 3) != 0);
			send_random(55);
			drain();
		end

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
